// File: src/tee_pkg.sv
package tee_pkg;

    // Table geometry: handles are 4 bits, so at most 16 slots are ever used.
    localparam int TABLE_MAX = 16;
    localparam int IDX_W     = 4;

    // Field widths
    localparam int RATE_W = 10;
    localparam int DUR_W  = 16;
    localparam int CNT_W  = 32;
    localparam int RK_W   = 2;

    // dur * rate fits in 26 bits (65535 * 1023 < 2^26)
    localparam int PROD_W = DUR_W + RATE_W;

    // x / 1000 == (x * RECIP) >> RECIP_SHIFT, exact for x < 2^26
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;
    localparam int PROD2_W = PROD_W + RECIP_W;
    localparam int SPAN_W  = PROD2_W - RECIP_SHIFT;

    // Input item kinds
    localparam logic IN_ADD  = 1'b0;
    localparam logic IN_TICK = 1'b1;

    // Result kinds
    localparam logic [RK_W-1:0] RK_ADD_OK   = 2'd0;
    localparam logic [RK_W-1:0] RK_ADD_FULL = 2'd1;
    localparam logic [RK_W-1:0] RK_EXPIRED  = 2'd2;

    // Config register indexes
    localparam logic REG_TICK_RATE = 1'b0;

    // Controller -> datapath commands
    typedef struct packed {
        logic             load;      // capture duration of an accepted item
        logic             tick_inc;  // advance the tick counter
        logic             mul1;      // duration * rate
        logic             mul2;      // scale by reciprocal of 1000
        logic             add_try;   // probe slot idx, claim it if free
        logic             add_full;  // report a refused add
        logic             rd_en;     // read deadline of slot idx for compare
        logic             flush;     // emit the held expiry as last
        logic [IDX_W-1:0] idx;
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic slot_free;
    } sts_t;

endpackage

// File: src/tee_ctrl.sv
module tee_ctrl #(
    parameter int USED = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          kind,
    output logic          busy,
    output tee_pkg::cmd_t cmd,
    input  tee_pkg::sts_t sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_MUL2  = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    localparam logic [tee_pkg::IDX_W-1:0] LAST_IDX = tee_pkg::IDX_W'(USED - 1);

    logic [2:0]                state_reg, state_next;
    logic [tee_pkg::IDX_W-1:0] idx_reg, idx_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    if (kind == tee_pkg::IN_ADD)
                    begin
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        cmd.tick_inc = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add_try = 1'b1;
                if (sts.slot_free)
                begin
                    state_next = S_IDLE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    cmd.add_full = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Accepted item always makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // Scan/probe index never runs past the last used slot.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.add_try || cmd.rd_en) |-> (idx_reg <= LAST_IDX))
        else $error("slot index beyond table");

    // A refused add only happens on the last slot, and only if it is taken.
    a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_full |-> (idx_reg == LAST_IDX && !sts.slot_free))
        else $error("add refused with slots left");

endmodule

// File: src/tee_dp.sv
module tee_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tee_pkg::cmd_t                cmd,
    output tee_pkg::sts_t                sts,
    input  logic [tee_pkg::DUR_W-1:0]    duration_ms,
    input  logic [tee_pkg::RATE_W-1:0]   tick_rate,
    output logic                         result_valid,
    output logic [tee_pkg::RK_W-1:0]     result_kind,
    output logic [tee_pkg::IDX_W-1:0]    handle,
    output logic                         last
);

    logic [tee_pkg::DUR_W-1:0]   dur_reg;
    logic [tee_pkg::PROD_W-1:0]  prod1_reg;
    logic [tee_pkg::PROD2_W-1:0] prod2_reg;
    logic [tee_pkg::CNT_W-1:0]   tick_count_reg;
    logic [tee_pkg::TABLE_MAX-1:0] valid_reg;

    logic [tee_pkg::CNT_W-1:0]   deadline_mem [tee_pkg::TABLE_MAX];
    logic [tee_pkg::CNT_W-1:0]   rd_data_reg;
    logic                        cmp_v_reg;
    logic [tee_pkg::IDX_W-1:0]   cmp_idx_reg;

    // one expiry is held back until we know whether it is the last
    logic                        pend_v_reg, pend_v_next;
    logic [tee_pkg::IDX_W-1:0]   pend_idx_reg, pend_idx_next;

    logic                        res_v_reg, res_v_next;
    logic [tee_pkg::RK_W-1:0]    res_kind_reg, res_kind_next;
    logic [tee_pkg::IDX_W-1:0]   res_handle_reg, res_handle_next;
    logic                        res_last_reg, res_last_next;

    logic [tee_pkg::CNT_W-1:0]   deadline;
    logic                        claim;
    logic                        hit;

    assign sts.slot_free = !valid_reg[cmd.idx];
    assign claim    = cmd.add_try && sts.slot_free;
    assign deadline = tick_count_reg
                    + tee_pkg::CNT_W'(prod2_reg[tee_pkg::PROD2_W-1:tee_pkg::RECIP_SHIFT]);
    assign hit      = cmp_v_reg && valid_reg[cmp_idx_reg] && (rd_data_reg <= tick_count_reg);

    // arithmetic pipe
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            dur_reg <= duration_ms;
        if (cmd.mul1)
            prod1_reg <= tee_pkg::PROD_W'(dur_reg) * tee_pkg::PROD_W'(tick_rate);
        if (cmd.mul2)
            prod2_reg <= tee_pkg::PROD2_W'(prod1_reg) * tee_pkg::PROD2_W'(tee_pkg::RECIP);
    end

    // deadline RAM, registered read
    always_ff @(posedge clk)
    begin
        if (claim)
            deadline_mem[cmd.idx] <= deadline;
        if (cmd.rd_en)
        begin
            rd_data_reg <= deadline_mem[cmd.idx];
            cmp_idx_reg <= cmd.idx;
        end
    end

    always_comb
    begin
        pend_v_next     = pend_v_reg;
        pend_idx_next   = pend_idx_reg;
        res_v_next      = 1'b0;
        res_kind_next   = res_kind_reg;
        res_handle_next = res_handle_reg;
        res_last_next   = res_last_reg;
        if (claim)
        begin
            res_v_next      = 1'b1;
            res_kind_next   = tee_pkg::RK_ADD_OK;
            res_handle_next = cmd.idx;
            res_last_next   = 1'b1;
        end
        else if (cmd.add_full)
        begin
            res_v_next      = 1'b1;
            res_kind_next   = tee_pkg::RK_ADD_FULL;
            res_handle_next = '0;
            res_last_next   = 1'b1;
        end
        else if (hit)
        begin
            // newer hit pushes the held one out as not-last
            res_v_next      = pend_v_reg;
            res_kind_next   = tee_pkg::RK_EXPIRED;
            res_handle_next = pend_idx_reg;
            res_last_next   = 1'b0;
            pend_v_next     = 1'b1;
            pend_idx_next   = cmp_idx_reg;
        end
        else if (cmd.flush)
        begin
            res_v_next      = pend_v_reg;
            res_kind_next   = tee_pkg::RK_EXPIRED;
            res_handle_next = pend_idx_reg;
            res_last_next   = 1'b1;
            pend_v_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            valid_reg      <= '0;
            cmp_v_reg      <= 1'b0;
            pend_v_reg     <= 1'b0;
            res_v_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.tick_inc)
                tick_count_reg <= tick_count_reg + 1'b1;
            if (claim)
                valid_reg[cmd.idx] <= 1'b1;
            else if (hit)
                valid_reg[cmp_idx_reg] <= 1'b0;
            cmp_v_reg  <= cmd.rd_en;
            pend_v_reg <= pend_v_next;
            res_v_reg  <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        res_kind_reg   <= res_kind_next;
        res_handle_reg <= res_handle_next;
        res_last_reg   <= res_last_next;
    end

    assign result_valid = res_v_reg;
    assign result_kind  = res_kind_reg;
    assign handle       = res_handle_reg;
    assign last         = res_last_reg;

    // Nothing may be held over from the previous tick.
    a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !pend_v_reg)
        else $error("expiry left pending at new item");

    // A slot that just expired is gone from the valid set.
    a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (hit && !claim) |=> !valid_reg[$past(cmp_idx_reg)])
        else $error("expired slot still valid");

    // A claimed slot was free and is valid afterwards.
    a_claim_sets: assert property (@(posedge clk) disable iff (!rst_n)
        claim |=> valid_reg[$past(cmd.idx)])
        else $error("claimed slot not marked valid");

endmodule

// File: src/timeout_expiry_table.sv
// Timeout expiry table.
// Command channel: drive kind/duration_ms with start; the item is taken on a
// clock edge where start is high and busy is low. kind 0 adds a timeout of
// duration_ms milliseconds, kind 1 is one timer tick.
// Result channel: result_valid marks each result transfer for one cycle; the
// receiver cannot stall it. result_kind/handle/last are valid with it, and
// last flags the final result of an item. A tick with nothing due gives none.
// Add: duration * tick_rate_hz / 1000 is formed in two registered multiplies
// (the divide is a reciprocal multiply), then free slots are probed one per
// cycle from slot 0 up to the first free slot (the last slot when full); busy
// covers the multiplies and the probe; the result follows in the next cycle.
// Tick: the counter advances at acceptance, then the deadline RAM is read one
// slot per cycle and compared in the cycle after, busy spanning the scan, drain
// and flush states; expiry results stream out during the scan, the last at its end.
// Config: APB, tick_rate_hz at byte address 0, readable; write it only while idle.
// Reset clears the tick counter, all slot valid bits and the control state;
// tick_rate_hz returns to 100. Deadlines need no clearing.
module timeout_expiry_table #(
    parameter int SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // command
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic [tee_pkg::DUR_W-1:0]   duration_ms,
    // results
    output logic                        result_valid,
    output logic [tee_pkg::RK_W-1:0]    result_kind,
    output logic [tee_pkg::IDX_W-1:0]   handle,
    output logic                        last,
    // APB config
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // only as many slots as a 4-bit handle can name
    localparam int USED = (SLOTS > tee_pkg::TABLE_MAX) ? tee_pkg::TABLE_MAX : SLOTS;

    logic [tee_pkg::RATE_W-1:0] rate_reg;
    logic                       wr_en;
    tee_pkg::cmd_t              cmd;
    tee_pkg::sts_t              sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                 && (paddr[2] == tee_pkg::REG_TICK_RATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_reg <= tee_pkg::RATE_W'(100);
        else if (wr_en)
            rate_reg <= pwdata[tee_pkg::RATE_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            tee_pkg::REG_TICK_RATE: prdata = 32'(rate_reg);
            default:                prdata = '0;
        endcase
    end

    tee_ctrl #(
        .USED (USED)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    tee_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .duration_ms  (duration_ms),
        .tick_rate    (rate_reg),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .handle       (handle),
        .last         (last)
    );

endmodule
